FILE: hw/rtl/msrm_pkg.sv
// Package for the minimal standard random block: controller states,
// command and status structs and generator constants.
// No dependencies.
package msrm_pkg;

    // generator constants, modulus 2^31-1 and multiplier 16807
    localparam int SEED_W = 31;
    localparam int RANGE_W = 32;
    localparam int MULT_W = 15;
    localparam int PROD_W = SEED_W + MULT_W;
    localparam logic [MULT_W-1:0] GEN_MULT = 15'd16807;
    localparam logic [SEED_W-1:0] GEN_MOD = 31'h7FFF_FFFF;
    localparam logic [SEED_W-1:0] SEED_RESET = 31'd1;

    // one quotient bit per step over the 31-bit dividend
    localparam int DIV_STEPS = SEED_W;
    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RED,
        ST_DIV,
        ST_DONE
    } msrm_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic mul;
        logic reduce;
        logic div_step;
        logic finish;
    } msrm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic range_zero;
        logic div_last;
        logic out_free;
    } msrm_status_t;

endpackage

FILE: hw/rtl/msrm_ctrl.sv
// Controller for the minimal standard random block: sequences the
// multiply, reduction, remainder steps and result hand-off.
// Depends on msrm_pkg.
module msrm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  msrm_pkg::msrm_status_t status,
    output msrm_pkg::msrm_cmd_t    cmd
);
    import msrm_pkg::*;

    msrm_state_t state_reg;
    msrm_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_RED;
            end
            ST_RED: begin
                state_next = status.range_zero ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (status.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                cmd.accept = s_valid;
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
            end
            ST_RED: begin
                cmd.reduce = 1'b1;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_DONE: begin
                cmd.finish = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/msrm_datapath.sv
// Datapath for the minimal standard random block: running seed,
// multiply and modulus reduction, radix-2 remainder and output register.
// Depends on msrm_pkg.
module msrm_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  msrm_pkg::msrm_cmd_t                   cmd,
    output msrm_pkg::msrm_status_t                status,
    input  logic signed [msrm_pkg::RANGE_W-1:0]   s_range_limit,
    input  logic                                  cfg_valid,
    input  logic        [msrm_pkg::SEED_W-1:0]    cfg_seed_load,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic        [msrm_pkg::SEED_W-1:0]    m_random_value
);
    import msrm_pkg::*;

    logic [SEED_W-1:0]  seed_reg;
    logic [SEED_W-1:0]  seed_fix;
    logic [PROD_W-1:0]  prod_reg;
    logic [SEED_W:0]    fold_sum;
    logic [SEED_W-1:0]  seed_new;
    logic [RANGE_W-1:0] mag_reg;
    logic               range_zero_reg;
    logic [SEED_W-1:0]  dividend_reg;
    logic [RANGE_W-1:0] rem_reg;
    logic [RANGE_W:0]   rem_trial;
    logic [RANGE_W-1:0] rem_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               out_valid_reg;
    logic [SEED_W-1:0]  out_value_reg;

    // zero seed acts as one
    assign seed_fix = (seed_reg == '0) ? SEED_RESET : seed_reg;

    // fold 2^31 back as 1, one subtract of the modulus
    assign fold_sum = {1'b0, prod_reg[SEED_W-1:0]}
                    + (SEED_W+1)'(prod_reg[PROD_W-1:SEED_W]);
    assign seed_new = (fold_sum >= {1'b0, GEN_MOD})
                    ? SEED_W'(fold_sum - {1'b0, GEN_MOD})
                    : fold_sum[SEED_W-1:0];

    // restoring remainder step
    assign rem_trial = {rem_reg, dividend_reg[SEED_W-1]};
    assign rem_next = (rem_trial >= {1'b0, mag_reg})
                    ? RANGE_W'(rem_trial - {1'b0, mag_reg})
                    : rem_trial[RANGE_W-1:0];

    // running seed, reloaded by a configuration write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SEED_RESET;
        end else if (cfg_valid) begin
            seed_reg <= cfg_seed_load;
        end else if (cmd.reduce) begin
            seed_reg <= seed_new;
        end
    end

    // request capture, product and remainder registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            range_zero_reg <= (s_range_limit == '0);
            mag_reg <= s_range_limit[RANGE_W-1] ? RANGE_W'(-s_range_limit)
                                                : RANGE_W'(s_range_limit);
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(seed_fix) * PROD_W'(GEN_MULT);
        end
        if (cmd.reduce) begin
            dividend_reg <= seed_new;
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            dividend_reg <= {dividend_reg[SEED_W-2:0], 1'b0};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_value_reg <= range_zero_reg ? seed_reg : rem_reg[SEED_W-1:0];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_random_value = out_value_reg;

    assign status.range_zero = range_zero_reg;
    assign status.div_last = (cnt_reg == CNT_LAST);
    assign status.out_free = !out_valid_reg || m_ready;

endmodule

FILE: hw/rtl/minimal_standard_random_modulo.sv
// Minimal standard random block, top level: controller and datapath.
// Depends on msrm_pkg, msrm_ctrl and msrm_datapath.
//
// Usage:
//   s_valid/s_ready carries a request with a signed range limit. Each
//   request advances the 31-bit seed (seed * 16807 mod 2^31-1, a zero
//   seed counting as one) and returns the new seed, or for a nonzero
//   range the new seed modulo the range's magnitude, on m_valid/m_ready.
//   cfg_valid/cfg_ready writes the starting seed; cfg_ready is always
//   high and a write reloads the running seed at once.
//   A request passes through the multiply and reduction states and, for
//   a nonzero range, the 31 steps of the one-bit-per-cycle remainder
//   unit before the result is loaded. One request is in flight at a time,
//   so a new request is taken in the cycle after the result is loaded.
//   The output register holds a finished result while the receiver
//   stalls; the next request is still taken and worked on, and waits in
//   the controller until the output register is free.
//   Reset (aresetn low, synchronous) sets the seed to one and empties
//   the output register.
module minimal_standard_random_modulo (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [msrm_pkg::RANGE_W-1:0] s_range_limit,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic        [msrm_pkg::SEED_W-1:0]  m_random_value,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic        [msrm_pkg::SEED_W-1:0]  cfg_seed_load
);
    import msrm_pkg::*;

    msrm_cmd_t    cmd;
    msrm_status_t status;

    // seed writes are always taken
    assign cfg_ready = 1'b1;

    // sequencing
    msrm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic and storage
    msrm_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_range_limit  (s_range_limit),
        .cfg_valid      (cfg_valid),
        .cfg_seed_load  (cfg_seed_load),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_random_value (m_random_value)
    );

endmodule

FILE: hw/rtl/msrm_checker.sv
// Port-level checks for the minimal standard random block, bound to
// the top level. Depends on msrm_pkg and minimal_standard_random_modulo.
module msrm_assert (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic        [msrm_pkg::SEED_W-1:0]  m_random_value,
    input logic                                cfg_ready
);
    import msrm_pkg::*;

    // a stalled result stays
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_random_value))
        else $error("result dropped or changed while stalled");

    // one request in flight
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // no result in the cycle after a request taken with an empty output
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared too early");

    // reset leaves the block idle and empty
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid && cfg_ready)
        else $error("block not idle after reset");

endmodule

bind minimal_standard_random_modulo msrm_assert u_msrm_assert (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_random_value (m_random_value),
    .cfg_ready      (cfg_ready)
);
